[src/imu_sfp_pkg.sv]
// Shared constants and types for the IMU serial frame parser.
// No dependencies; imported by imu_serial_frame_parser and its testbench.
package imu_sfp_pkg;

  // Frame layout
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned PAYLOAD_LEN = 8;

  // Byte counter: holds 0 .. FRAME_LEN-1
  localparam int unsigned CNT_W = 4;
  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t CNT_HDR  = cnt_t'(0);
  localparam cnt_t CNT_TYPE = cnt_t'(1);
  localparam cnt_t CNT_PL0  = cnt_t'(2);
  localparam cnt_t CNT_CSUM = cnt_t'(FRAME_LEN - 1);

  localparam int unsigned PIDX_W = $clog2(PAYLOAD_LEN);
  typedef logic [PIDX_W-1:0] pidx_t;

  // Yaw scaling: raw * 180 gives degrees with 15 fraction bits
  localparam logic signed [8:0] YAW_SCALE = 9'sd180;
  localparam int unsigned YAW_Q_W = 24;

  // Result kind codes
  typedef enum logic {
    KIND_GYRO  = 1'b0,
    KIND_ANGLE = 1'b1
  } kind_t;

endpackage

[src/imu_serial_frame_parser.sv]
// IMU serial frame parser, top level.
// Depends on imu_sfp_pkg.
// Usage:
//   Input channel: one received serial byte per word on in_rx_byte with
//   in_valid/in_ready. The parser hunts for header 0x55 and gathers an
//   11-byte frame (header, type, 8 payload bytes, checksum; checksum is
//   not checked). A header value inside a frame is taken as data.
//   Output channel: on the checksum byte of a gyro (0x52) or angle (0x53)
//   frame one result word is presented: kind, four little-endian signed
//   16-bit payload words and the stored yaw times 180 (Q15 degrees).
//   Angle frames update the stored yaw before the result is formed.
//   Other frame types produce nothing.
//   Output timing: a result is registered and appears in the cycle after its checksum byte is taken.
//   Throughput: one byte per cycle while in_ready is high; all per-byte work sits between the
//   frame state registers and the output register.
//   Reset (rst_n low, synchronous): byte counter, stored yaw and output
//   valid clear; the parser starts hunting for a header.
//   Stall: a result waiting in the output register does not block input
//   as long as out_ready is high in the same cycle; with out_ready low
//   and a result pending, in_ready drops until the result is taken.
module imu_serial_frame_parser
  import imu_sfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_packet_kind,
  output logic signed [15:0] out_word_a,
  output logic signed [15:0] out_word_b,
  output logic signed [15:0] out_word_c,
  output logic signed [15:0] out_word_d,
  output logic signed [23:0] out_yaw_q15
);

  // Frame state
  cnt_t        byte_count_r, byte_count_nxt;
  logic [7:0]  frame_type_r;
  logic [7:0]  payload_r [PAYLOAD_LEN];
  logic [15:0] yaw_raw_r, yaw_raw_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               kind_r;
  logic signed [15:0] word_a_r, word_b_r, word_c_r, word_d_r;
  logic signed [23:0] yaw_q15_r;

  logic        accept;
  logic        is_csum;
  logic        known_type;
  logic        is_angle;
  pidx_t       pl_idx;
  logic [15:0] w_a, w_b, w_c, w_d;
  logic signed [YAW_Q_W-1:0] yaw_prod;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Payload slot for the current data byte
  assign pl_idx  = pidx_t'(byte_count_r - CNT_PL0);
  assign is_csum = (byte_count_r >= CNT_CSUM);

  // Little-endian words from the gathered payload
  assign w_a = {payload_r[1], payload_r[0]};
  assign w_b = {payload_r[3], payload_r[2]};
  assign w_c = {payload_r[5], payload_r[4]};
  assign w_d = {payload_r[7], payload_r[6]};

  assign is_angle   = (frame_type_r == TYPE_ANGLE);
  assign known_type = is_angle || (frame_type_r == TYPE_GYRO);

  // Byte counter and stored yaw
  always_comb begin
    byte_count_nxt = byte_count_r;
    yaw_raw_nxt    = yaw_raw_r;
    if (accept) begin
      if (byte_count_r == CNT_HDR) begin
        if (in_rx_byte == HDR_BYTE) begin
          byte_count_nxt = CNT_TYPE;
        end
      end else if (is_csum) begin
        byte_count_nxt = CNT_HDR;
        if (is_angle) begin
          yaw_raw_nxt = w_c;
        end
      end else begin
        byte_count_nxt = byte_count_r + cnt_t'(1);
      end
    end
  end

  // Yaw in Q15 degrees from the updated yaw; the product always fits 24 bits
  assign yaw_prod = YAW_Q_W'($signed(yaw_raw_nxt)) * YAW_Q_W'(YAW_SCALE);

  // Result handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && is_csum && known_type) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= CNT_HDR;
      yaw_raw_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      yaw_raw_r    <= yaw_raw_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Type and payload capture
  always_ff @(posedge clk) begin
    if (accept && byte_count_r == CNT_TYPE) begin
      frame_type_r <= in_rx_byte;
    end
    if (accept && byte_count_r >= CNT_PL0 && !is_csum) begin
      payload_r[pl_idx] <= in_rx_byte;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (accept && is_csum && known_type) begin
      kind_r    <= is_angle ? KIND_ANGLE : KIND_GYRO;
      word_a_r  <= $signed(w_a);
      word_b_r  <= $signed(w_b);
      word_c_r  <= $signed(w_c);
      word_d_r  <= $signed(w_d);
      yaw_q15_r <= yaw_prod;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packet_kind = kind_r;
  assign out_word_a      = word_a_r;
  assign out_word_b      = word_b_r;
  assign out_word_c      = word_c_r;
  assign out_word_d      = word_d_r;
  assign out_yaw_q15     = yaw_q15_r;

endmodule

[sim/tb_imu_serial_frame_parser.sv]
// Self-checking testbench for imu_serial_frame_parser: byte stream in, frame results out.
// Depends on imu_sfp_pkg and the parser RTL; a built-in frame predictor scores every result.
module tb_imu_serial_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import imu_sfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_ERR_PRINTS = 100;
  localparam int unsigned PHASE_BYTES    = 270;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    logic signed [15:0] word_c;
    logic signed [15:0] word_d;
    logic signed [23:0] yaw_q15;
  } imu_sample_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_packet_kind;
  logic signed [15:0] out_word_a;
  logic signed [15:0] out_word_b;
  logic signed [15:0] out_word_c;
  logic signed [15:0] out_word_d;
  logic signed [23:0] out_yaw_q15;

  imu_serial_frame_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packet_kind (out_packet_kind),
    .out_word_a      (out_word_a),
    .out_word_b      (out_word_b),
    .out_word_c      (out_word_c),
    .out_word_d      (out_word_d),
    .out_yaw_q15     (out_yaw_q15)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Frame predictor state
  cnt_t               pred_pos = CNT_HDR;
  logic [7:0]         pred_type = 8'h00;
  logic [7:0]         pred_payload [PAYLOAD_LEN];
  logic signed [15:0] pred_yaw_raw = 16'sd0;
  imu_sample_t        expected_samples [$];

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_gyro = 0;
  int unsigned n_angle = 0;
  int unsigned n_unknown = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;

  function automatic logic signed [15:0] payload_word(int unsigned k);
    return {pred_payload[pidx_t'(2*k+1)], pred_payload[pidx_t'(2*k)]};
  endfunction

  // Advance the frame tracker by one accepted byte; queue a result on a
  // completed gyro or angle frame.
  function automatic void parse_byte(logic [7:0] b);
    imu_sample_t        s;
    logic signed [23:0] yaw_wide;
    if (pred_pos == CNT_HDR) begin
      // hunting: anything but the header is dropped
      if (b == HDR_BYTE) pred_pos = CNT_TYPE;
    end else if (pred_pos == CNT_TYPE) begin
      pred_type = b;
      pred_pos = CNT_PL0;
    end else if (pred_pos < CNT_CSUM) begin
      // header value in here is plain data
      pred_payload[pidx_t'(pred_pos - CNT_PL0)] = b;
      pred_pos = pred_pos + 1'b1;
    end else begin
      // checksum byte closes the frame, value ignored
      pred_pos = CNT_HDR;
      if (pred_type == TYPE_GYRO || pred_type == TYPE_ANGLE) begin
        if (pred_type == TYPE_ANGLE) begin
          pred_yaw_raw = payload_word(2);
          n_angle++;
        end else begin
          n_gyro++;
        end
        s.kind = (pred_type == TYPE_ANGLE) ? KIND_ANGLE : KIND_GYRO;
        s.word_a = payload_word(0);
        s.word_b = payload_word(1);
        s.word_c = payload_word(2);
        s.word_d = payload_word(3);
        yaw_wide = 24'(pred_yaw_raw);
        s.yaw_q15 = yaw_wide * 24'(YAW_SCALE);
        expected_samples.push_back(s);
      end else begin
        n_unknown++;
      end
    end
  endfunction

  function automatic void compare_field(string field, logic signed [23:0] want,
                                        logic signed [23:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_ERR_PRINTS)
        $display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function automatic void check_sample();
    imu_sample_t s;
    if (expected_samples.size() == 0) begin
      n_errors++;
      if (n_errors <= MAX_ERR_PRINTS)
        $display("%0t result word with none pending: kind %0d yaw %0d",
                 $time, out_packet_kind, out_yaw_q15);
    end else begin
      s = expected_samples.pop_front();
      n_checked++;
      compare_field("packet_kind", 24'(s.kind), 24'(out_packet_kind));
      compare_field("word_a", 24'(s.word_a), 24'(out_word_a));
      compare_field("word_b", 24'(s.word_b), 24'(out_word_b));
      compare_field("word_c", 24'(s.word_c), 24'(out_word_c));
      compare_field("word_d", 24'(s.word_d), 24'(out_word_d));
      compare_field("yaw_q15", s.yaw_q15, out_yaw_q15);
    end
  endfunction

  // Watch both channels; values are pre-edge since all drivers are nonblocking
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) parse_byte(in_rx_byte);
      if (out_valid && out_ready) check_sample();
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte word; returns at the edge that takes it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Send the first len bytes of a frame
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] wa, wb, wc, wd,
                            input logic [7:0] csum, input int unsigned len);
    logic [7:0] fb [FRAME_LEN];
    fb[0] = HDR_BYTE;
    fb[1] = ftype;
    {fb[3], fb[2]} = wa;
    {fb[5], fb[4]} = wb;
    {fb[7], fb[6]} = wc;
    {fb[9], fb[8]} = wd;
    fb[10] = csum;
    for (int i = 0; i < len; i++) send_byte(fb[i]);
  endtask

  // Hold the sender off until every predicted result is out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_samples.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Noise while hunting, then angle and gyro frames at the word extremes,
  // header value used as data and as checksum
  task automatic test_extreme_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, HDR_BYTE, FRAME_LEN);
    send_frame(TYPE_GYRO, 16'h5555, 16'h0000, 16'h7FFF, 16'h5555, 8'h00, FRAME_LEN);
  endtask

  // Unknown type is swallowed and must leave the stored yaw alone
  task automatic test_unknown_type();
    send_frame(HDR_BYTE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hFF, FRAME_LEN);
    send_frame(TYPE_GYRO, 16'h0001, 16'hFFFE, 16'h0000, 16'h8000, 8'hAA, FRAME_LEN);
  endtask

  // Mostly whole gyro/angle frames with random content, plus noise,
  // odd types and truncated frames
  task automatic test_random_frames(input int unsigned in_pct, input int unsigned out_pct);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  ftype;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    start = n_sent;
    while (n_sent - start < PHASE_BYTES) begin
      repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
      pick = $urandom_range(9);
      if (pick < 4) ftype = TYPE_GYRO;
      else if (pick < 8) ftype = TYPE_ANGLE;
      else ftype = 8'($urandom_range(255));
      len = ($urandom_range(9) == 0) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
      send_frame(ftype, pick_word(), pick_word(), pick_word(), pick_word(),
                 8'($urandom_range(255)), len);
    end
  endtask

  initial begin
    in_idle_pct = 12;
    out_idle_pct = 53;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_frames();
    test_unknown_type();
    wait_for_results();
    test_random_frames(12, 53);
    wait_for_results();
    test_random_frames(53, 12);
    wait_for_results();
    test_random_frames(0, 0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes under three stall mixes; checked %0d results", n_sent, n_checked);
    $display("  (%0d gyro, %0d angle frames; %0d unknown-type frames dropped)",
             n_gyro, n_angle, n_unknown);
    if (n_errors == 0 && expected_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
src/imu_sfp_pkg.sv
src/imu_serial_frame_parser.sv
sim/tb_imu_serial_frame_parser.sv
